// ----- hdl/t2te_pkg.sv -----
package t2te_pkg;

  localparam int TILE_DIM = 8;
  localparam int ROW_W    = 2 * TILE_DIM;
  localparam int IDX_W    = $clog2(TILE_DIM);
  localparam int BIT_W    = $clog2(ROW_W);
  localparam int PIX_W    = 2;
  localparam int CMD_W    = 4;
  localparam int DATA_W   = 16;

  // Command codes; anything above CMD_TURN_B behaves as a read.
  localparam logic [CMD_W-1:0] CMD_READ   = 4'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_SET    = 4'd2;
  localparam logic [CMD_W-1:0] CMD_FILL   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_INVERT = 4'd4;
  localparam logic [CMD_W-1:0] CMD_SHL    = 4'd5;
  localparam logic [CMD_W-1:0] CMD_SHR    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_UP     = 4'd7;
  localparam logic [CMD_W-1:0] CMD_DOWN   = 4'd8;
  localparam logic [CMD_W-1:0] CMD_TURN_A = 4'd9;
  localparam logic [CMD_W-1:0] CMD_TURN_B = 4'd10;

  localparam logic [PIX_W-1:0] PIX_ALL_ONES = 2'b11;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [BIT_W-1:0] bit_idx_t;
  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef row_t [TILE_DIM-1:0] tile_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    idx_t              pixel_row;
    idx_t              pixel_col;
    pix_t              color;
    logic [DATA_W-1:0] row_data;
  } in_item_t;

  // Pixel 0 sits in the top two bits of a row.
  function automatic pix_t get_px(row_t v, idx_t c);
    bit_idx_t base;
    base = bit_idx_t'(ROW_W - 1 - PIX_W * int'(c));
    return v[base -: PIX_W];
  endfunction

  function automatic row_t put_px(row_t v, idx_t c, pix_t p);
    row_t     res;
    bit_idx_t base;
    res  = v;
    base = bit_idx_t'(ROW_W - 1 - PIX_W * int'(c));
    res[base -: PIX_W] = p;
    return res;
  endfunction

endpackage

// ----- hdl/t2te_in_if.sv -----
interface t2te_in_if;
  import t2te_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  idx_t              pixel_row;
  idx_t              pixel_col;
  pix_t              color;
  logic [DATA_W-1:0] row_data;

  modport source (output valid, cmd, pixel_row, pixel_col, color, row_data, input ready);
  modport sink   (input valid, cmd, pixel_row, pixel_col, color, row_data, output ready);
endinterface

// ----- hdl/t2te_out_if.sv -----
interface t2te_out_if;
  import t2te_pkg::*;

  logic valid;
  logic ready;
  row_t row_out;
  pix_t pixel_out;

  modport source (output valid, row_out, pixel_out, input ready);
  modport sink   (input valid, row_out, pixel_out, output ready);
endinterface

// ----- hdl/t2te_xform.sv -----
module t2te_xform (
  input  t2te_pkg::tile_t    tile,
  input  t2te_pkg::in_item_t item,
  output t2te_pkg::tile_t    tile_nxt,
  output t2te_pkg::row_t     row_out,
  output t2te_pkg::pix_t     pixel_out
);
  import t2te_pkg::*;

  localparam int LAST = TILE_DIM - 1;

  always_comb begin
    tile_nxt = tile;
    case (item.cmd)
      CMD_WRITE: begin
        tile_nxt[item.pixel_row] = ROW_W'(item.row_data);
      end
      CMD_SET: begin
        tile_nxt[item.pixel_row] = put_px(tile[item.pixel_row], item.pixel_col, item.color);
      end
      CMD_FILL: begin
        for (int r = 0; r < TILE_DIM; r++) tile_nxt[idx_t'(r)] = {TILE_DIM{item.color}};
      end
      CMD_INVERT: begin
        for (int r = 0; r < TILE_DIM; r++) tile_nxt[idx_t'(r)] = ~tile[idx_t'(r)];
      end
      CMD_SHL: begin
        for (int r = 0; r < TILE_DIM; r++)
          tile_nxt[idx_t'(r)] = {tile[idx_t'(r)][ROW_W-PIX_W-1:0],
                                 tile[idx_t'(r)][ROW_W-1 -: PIX_W]};
      end
      CMD_SHR: begin
        for (int r = 0; r < TILE_DIM; r++)
          tile_nxt[idx_t'(r)] = {tile[idx_t'(r)][PIX_W-1:0],
                                 tile[idx_t'(r)][ROW_W-1:PIX_W]};
      end
      CMD_UP: begin
        for (int r = 0; r < TILE_DIM; r++)
          tile_nxt[idx_t'(r)] = tile[idx_t'((r + 1) % TILE_DIM)];
      end
      CMD_DOWN: begin
        for (int r = 0; r < TILE_DIM; r++)
          tile_nxt[idx_t'(r)] = tile[idx_t'((r + LAST) % TILE_DIM)];
      end
      CMD_TURN_A: begin
        // new (r, c) takes old (row c, column last-r)
        for (int r = 0; r < TILE_DIM; r++)
          for (int c = 0; c < TILE_DIM; c++)
            tile_nxt[idx_t'(r)] = put_px(tile_nxt[idx_t'(r)], idx_t'(c),
                                         get_px(tile[idx_t'(c)], idx_t'(LAST - r)));
      end
      CMD_TURN_B: begin
        // new (r, c) takes old (row last-c, column r)
        for (int r = 0; r < TILE_DIM; r++)
          for (int c = 0; c < TILE_DIM; c++)
            tile_nxt[idx_t'(r)] = put_px(tile_nxt[idx_t'(r)], idx_t'(c),
                                         get_px(tile[idx_t'(LAST - c)], idx_t'(r)));
      end
      default: begin
        tile_nxt = tile;
      end
    endcase
  end

  assign row_out   = tile_nxt[item.pixel_row];
  assign pixel_out = get_px(tile_nxt[item.pixel_row], item.pixel_col);

endmodule

// ----- hdl/tile_2bpp_transform_engine.sv -----
// A result is registered and shows on out_ch in the cycle after its input transfer.
// Throughput: one command per cycle while out_ch is ready; the whole tile
//   update is one logic pass from tile register and input fields to itself.
// Reset (synchronous, rst_n low): clear all eight tile rows to zero and drop
//   any pending result.
module tile_2bpp_transform_engine (
  input logic         clk,
  input logic         rst_n,
  t2te_in_if.sink     in_ch,
  t2te_out_if.source  out_ch
);
  import t2te_pkg::*;

  // Tile store: eight packed rows held in flops.
  tile_t    tile_r;
  tile_t    tile_nxt;

  // Result register; it parts the input side from the output side.
  logic     out_valid_r;
  row_t     out_row_r;
  pix_t     out_pixel_r;
  row_t     row_nxt;
  pix_t     pixel_nxt;

  in_item_t item;
  logic     in_fire;

  // Take a new command whenever the result register is empty or being
  // drained in this same cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign item = '{
    cmd:       in_ch.cmd,
    pixel_row: in_ch.pixel_row,
    pixel_col: in_ch.pixel_col,
    color:     in_ch.color,
    row_data:  in_ch.row_data
  };

  // Apply the command to the whole tile and pick the addressed row and pixel
  // out of the updated tile.
  t2te_xform u_xform (
    .tile      (tile_r),
    .item      (item),
    .tile_nxt  (tile_nxt),
    .row_out   (row_nxt),
    .pixel_out (pixel_nxt)
  );

  // Tile state: advance only on an input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_r <= '0;
    end else if (in_fire) begin
      tile_r <= tile_nxt;
    end
  end

  // Result valid: set on an input transfer, drop once the output transfer
  // completes with nothing new behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: hold while stalled, load with each accepted command.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_row_r   <= row_nxt;
      out_pixel_r <= pixel_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.row_out   = out_row_r;
  assign out_ch.pixel_out = out_pixel_r;

  // Every accepted command yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted command produced no result");

  // A read leaves the tile untouched.
  a_read_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_ch.cmd == CMD_READ) |=> $stable(tile_r))
    else $error("read command changed the tile");

  // After a fill the returned pixel is the fill color.
  a_fill_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_ch.cmd == CMD_FILL) |=> out_pixel_r == $past(in_ch.color))
    else $error("fill returned a wrong pixel");

  // Invert flips every bit of the addressed row.
  a_invert_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_ch.cmd == CMD_INVERT)
      |=> out_row_r == ~($past(tile_r[in_ch.pixel_row])))
    else $error("invert returned a wrong row");

endmodule
